// File: rtl/core/sha1_pkg.sv
// Shared types and constants for the SHA-1 hash engine.
// Used by sha1_compress and sha1_hash_engine; depends on nothing else.

package sha1_pkg;

  // Initial chaining value, word 0 in the lowest slot.
  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_00_19 = 32'h5A827999;
  localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
  localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
  localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

  localparam logic [6:0] ROUND_LAST  = 7'd79;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] BLOCK_LAST  = 6'd63;
  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [2:0] DIGEST_LAST = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_FINAL
  } core_state_e;

  typedef struct packed {
    logic       load;
    logic [7:0] data;
    logic       start;
    logic       init;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
  } core_stat_t;

endpackage

// File: rtl/core/sha1_hash_engine.sv
// SHA-1 hash engine top level: input sequencer, padding and digest output.
// Depends on sha1_pkg and instantiates sha1_compress.
//
// Usage: the slave stream carries one message byte per transaction in
// tdata, tuser says whether the byte is present and tlast ends the message.
// A byte that neither completes a 64-byte block nor carries tlast is taken
// with the block staying ready. The 64th byte of a block starts the
// compression: 80 rounds at one round per cycle on the shared round adder,
// then a chaining add and a hand-back state, with tready low throughout.
// On tlast the block pads the message one byte per cycle while no
// compression runs (9 to 72 bytes, with one or two compressions), then
// presents the digest on the master stream as five 32-bit words, H0 first;
// tuser carries the word index and tlast marks the fifth word. Output
// words come from a register and hold while tready is low; no input is
// taken until the fifth word is taken, at which point the chaining value
// and byte count reinitialize. Reset returns the chaining value to the
// standard initial constants, clears the byte count and leaves the block
// ready with no output pending.

module sha1_hash_engine import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] msg_byte
  input  logic        s_axis_tuser_i,   // [0] byte_present
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o
);

  top_state_e  state_q, state_d;
  top_state_e  after_q, after_d;
  logic [60:0] count_q, count_d;
  logic [63:0] len_q, len_d;
  logic        first_q, first_d;
  logic        lp_q, lp_d;

  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic [2:0]  out_idx_q;
  logic        out_last_q;

  core_ctrl_t  core_ctrl;
  core_stat_t  core_stat;
  logic [2:0]  word_sel;
  logic [31:0] core_word;

  logic [5:0]  pos;
  logic        in_acc;
  logic        out_acc;
  logic        block_full;
  logic        pad_done;
  logic        is_len;
  logic        load_first;

  assign pos     = count_q[5:0];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_idx_q;
  assign m_axis_tlast_o  = out_last_q;

  sha1_compress u_compress (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (core_ctrl),
    .word_sel_i (word_sel),
    .stat_o     (core_stat),
    .word_o     (core_word)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    after_d = after_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (block_full) begin
            state_d = ST_COMP;
            after_d = s_axis_tlast_i ? ST_PAD : ST_IDLE;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (block_full) begin
          state_d = ST_COMP;
          after_d = pad_done ? ST_OUT : ST_PAD;
        end
      end
      ST_COMP: begin
        if (!core_stat.busy) state_d = after_q;
      end
      ST_OUT: begin
        if (out_acc && out_last_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: byte feed, padding, length bookkeeping and the restart after the digest.
  always_comb begin
    core_ctrl  = '0;
    count_d    = count_q;
    len_d      = len_q;
    first_d    = first_q;
    lp_d       = lp_q;
    block_full = 1'b0;
    pad_done   = 1'b0;
    is_len     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && s_axis_tuser_i) begin
          core_ctrl.load = 1'b1;
          core_ctrl.data = s_axis_tdata_i;
          count_d        = 61'(count_q + 61'd1);
          block_full     = (pos == BLOCK_LAST);
        end
        if (in_acc && s_axis_tlast_i) begin
          len_d   = {count_d, 3'b000};
          first_d = 1'b1;
          lp_d    = 1'b0;
        end
      end
      ST_PAD: begin
        // Zeros run until byte 56 of a block, then the eight length bytes follow.
        is_len         = !first_q && (lp_q || pos == LEN_POS);
        core_ctrl.load = 1'b1;
        if (first_q) begin
          core_ctrl.data = PAD_MARK;
        end else if (is_len) begin
          core_ctrl.data = len_q[63:56];
        end else begin
          core_ctrl.data = 8'h00;
        end
        count_d    = 61'(count_q + 61'd1);
        first_d    = 1'b0;
        if (is_len) begin
          lp_d  = 1'b1;
          len_d = {len_q[55:0], 8'h00};
        end
        block_full = (pos == BLOCK_LAST);
        pad_done   = is_len && (pos == BLOCK_LAST);
      end
      ST_COMP: begin
      end
      ST_OUT: begin
        if (out_acc && out_last_q) begin
          core_ctrl.init = 1'b1;
          count_d        = '0;
        end
      end
      default: begin
      end
    endcase
    core_ctrl.start = block_full;
  end

  assign load_first = (state_q == ST_COMP) && !core_stat.busy && (after_q == ST_OUT);
  assign word_sel   = load_first ? 3'd0 : 3'(out_idx_q + 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      after_q     <= ST_IDLE;
      count_q     <= '0;
      first_q     <= 1'b0;
      lp_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      count_q <= count_d;
      first_q <= first_d;
      lp_q    <= lp_d;
      if (load_first) begin
        out_valid_q <= 1'b1;
        out_idx_q   <= '0;
        out_last_q  <= 1'b0;
      end else if (out_acc) begin
        if (out_last_q) begin
          out_valid_q <= 1'b0;
        end else begin
          out_idx_q  <= word_sel;
          out_last_q <= (word_sel == DIGEST_LAST);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    if (load_first || (out_acc && !out_last_q)) begin
      out_data_q <= core_word;
    end
  end

`ifndef SYNTHESIS
  // Input is only taken while the round unit is quiet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !core_stat.busy)
    else $error("input accepted while compression is running");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a digest is still being delivered");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o == DIGEST_LAST)))
    else $error("last digest word flag does not match the word index");

  // Every padding cycle feeds exactly one byte into the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD) |=> (count_q == 61'($past(count_q) + 61'd1)))
    else $error("padding cycle did not advance the byte count");
`endif

endmodule

// File: rtl/core/sha1_compress.sv
// SHA-1 block buffer, message schedule and round unit, one round per cycle.
// Depends on sha1_pkg for constants and the control/status structs.

module sha1_compress import sha1_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  core_ctrl_t ctrl_i,
  input  logic [2:0] word_sel_i,
  output core_stat_t stat_o,
  output logic [31:0] word_o
);

  core_state_e state_q, state_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [31:0] win_q [16];
  logic [31:0] regs_q [5];
  logic [31:0] chain_q [5];

  logic [31:0] w_cur;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] tmp;
  logic [31:0] sched_x;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CORE_IDLE:  if (ctrl_i.start) state_d = CORE_ROUND;
      CORE_ROUND: if (rnd_q == ROUND_LAST) state_d = CORE_FINAL;
      CORE_FINAL: state_d = CORE_IDLE;
      default:    state_d = CORE_IDLE;
    endcase
  end

  always_comb begin
    rnd_d = rnd_q;
    if (state_q == CORE_IDLE) begin
      rnd_d = '0;
    end else if (state_q == CORE_ROUND) begin
      rnd_d = 7'(rnd_q + 7'd1);
    end
  end

  assign stat_o.busy = (state_q != CORE_IDLE);

  // The window keeps W[t-16] in slot 0; the first 16 rounds recirculate it.
  always_comb begin
    sched_x = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
    w_cur   = (rnd_q < 7'd16) ? win_q[0] : {sched_x[30:0], sched_x[31]};
  end

  always_comb begin
    if (rnd_q < 7'd20) begin
      f_val = regs_q[3] ^ (regs_q[1] & (regs_q[2] ^ regs_q[3]));
      k_val = K_00_19;
    end else if (rnd_q < 7'd40) begin
      f_val = regs_q[1] ^ regs_q[2] ^ regs_q[3];
      k_val = K_20_39;
    end else if (rnd_q < 7'd60) begin
      f_val = (regs_q[1] & regs_q[2]) | (regs_q[3] & (regs_q[1] | regs_q[2]));
      k_val = K_40_59;
    end else begin
      f_val = regs_q[1] ^ regs_q[2] ^ regs_q[3];
      k_val = K_60_79;
    end
    tmp = {regs_q[0][26:0], regs_q[0][31:27]} + f_val + regs_q[4] + k_val + w_cur;
  end

  always_comb begin
    case (word_sel_i)
      3'd0:    word_o = chain_q[0];
      3'd1:    word_o = chain_q[1];
      3'd2:    word_o = chain_q[2];
      3'd3:    word_o = chain_q[3];
      3'd4:    word_o = chain_q[4];
      default: word_o = chain_q[4];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  // Incoming bytes shift through the window, so it doubles as the block buffer.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_q[15] <= {win_q[15][23:0], ctrl_i.data};
    end else if (state_q == CORE_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= w_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        chain_q[i] <= H_INIT[i];
        regs_q[i]  <= '0;
      end
    end else begin
      if (ctrl_i.init) begin
        for (int i = 0; i < 5; i++) chain_q[i] <= H_INIT[i];
      end else if (state_q == CORE_FINAL) begin
        for (int i = 0; i < 5; i++) chain_q[i] <= chain_q[i] + regs_q[i];
      end
      if (ctrl_i.start && state_q == CORE_IDLE) begin
        for (int i = 0; i < 5; i++) regs_q[i] <= chain_q[i];
      end else if (state_q == CORE_ROUND) begin
        regs_q[4] <= regs_q[3];
        regs_q[3] <= regs_q[2];
        regs_q[2] <= {regs_q[1][1:0], regs_q[1][31:2]};
        regs_q[1] <= regs_q[0];
        regs_q[0] <= tmp;
      end
    end
  end

endmodule

// File: sim/tb_sha1_hash_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for sha1_hash_engine: byte streams in, digest words out.
// Needs only the RTL; expected digests come from a SHA-1 predictor or known answers.

module tb_sha1_hash_engine;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int ITEMS_WANTED = 350;
  localparam int CALM_ITEMS   = 50;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 300;
  localparam int SQUEEZE_HOLD = 300;
  localparam int MAX_IDLE     = 13;

  localparam int          DIGEST_WORDS = 5;
  localparam logic [7:0]  PAD_BYTE     = 8'h80;
  localparam logic [5:0]  LEN_OFFSET   = 6'd56;
  localparam logic [5:0]  BLOCK_END    = 6'd63;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] RC0 = 32'h5A827999;
  localparam logic [31:0] RC1 = 32'h6ED9EBA1;
  localparam logic [31:0] RC2 = 32'h8F1BBCDC;
  localparam logic [31:0] RC3 = 32'hCA62C1D6;

  localparam logic [159:0] DIGEST_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] DIGEST_ABC   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         eom;
    logic         typed;    // digest below is the known answer
    logic [159:0] digest;
  } stim_row_t;

  localparam int N_ROWS = 13;
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
    '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
    '{8'hFF, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
    '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hA5, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h5A, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h7E, 1'b0, 1'b1, 1'b0, 160'h0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // Predictor state.
  logic [31:0] chain [DIGEST_WORDS];
  logic [7:0]  blk_bytes [64];
  logic [60:0] msg_bytes;

  digest_word_t digest_q [$];
  int err_count = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit squeeze_armed = 1'b0;

  sha1_hash_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void restart_chain();
    chain[0] = IV0;
    chain[1] = IV1;
    chain[2] = IV2;
    chain[3] = IV3;
    chain[4] = IV4;
    msg_bytes = '0;
  endfunction

  function automatic void fold_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, x, sum;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RC0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RC1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RC2;
      end else begin
        f = b ^ c ^ d;
        k = RC3;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  function automatic void append_byte(input logic [7:0] value);
    logic [5:0] pos;
    pos = msg_bytes[5:0];
    blk_bytes[pos] = value;
    msg_bytes = msg_bytes + 61'd1;
    if (pos == BLOCK_END) fold_block();
  endfunction

  // Returns 1 when the item closes a message; the digest is then in dig, H0 on top.
  function automatic bit predict_digest(input logic [7:0] value, input logic present,
                                        input logic eom, output logic [159:0] dig);
    logic [63:0] bit_len;
    dig = '0;
    if (present) append_byte(value);
    if (!eom) return 1'b0;
    bit_len = {msg_bytes, 3'b000};
    append_byte(PAD_BYTE);
    while (msg_bytes[5:0] != LEN_OFFSET) append_byte(8'h00);
    for (int i = 0; i < 8; i++) append_byte(bit_len[63 - 8*i -: 8]);
    dig = {chain[0], chain[1], chain[2], chain[3], chain[4]};
    restart_chain();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  // Offers one input transaction, possibly after an idle burst, and books its digest.
  task automatic send_item(input logic [7:0] value, input logic present, input logic eom,
                           input logic typed, input logic [159:0] known_dig);
    logic [159:0] dig;
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= present;
    s_axis_tlast_i  <= eom;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (predict_digest(value, present, eom, dig)) begin
      if (typed) dig = known_dig;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        digest_q.push_back('{dig[159 - 32*i -: 32], 3'(i), i == DIGEST_WORDS - 1});
      end
    end
  endtask

  initial begin : stimulus
    int n_items;
    int len;
    bit tail_end;
    n_items = 0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    s_axis_tuser_i  <= 1'b0;
    s_axis_tlast_i  <= 1'b0;
    restart_chain();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_ROWS; r++) begin
      send_item(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].present, DIRECTED_ROWS[r].eom,
                DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].digest);
    end

    // Messages with random content; lengths cluster around the padding boundaries.
    squeeze_armed = 1'b1;
    while (n_items < ITEMS_WANTED) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(0, 8);
        4:          len = $urandom_range(55, 56);
        5:          len = $urandom_range(63, 65);
        6:          len = $urandom_range(119, 120);
        default:    len = $urandom_range(9, 40);
      endcase
      tail_end = (len > 0) && $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
        end
        send_item(8'($urandom_range(0, 255)), 1'b1, tail_end && (i == len - 1), 1'b0, '0);
        n_items++;
        if (n_items >= ITEMS_WANTED - CALM_ITEMS) calm = 1'b1;
      end
      if (!tail_end) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
        n_items++;
      end
      if (n_items >= ITEMS_WANTED - CALM_ITEMS) calm = 1'b1;
    end
    s_axis_tvalid_i <= 1'b0;

    wait (digest_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Output side: random stalls, plus one long hold-off so the engine backs up.
  initial begin : digest_sink
    int stall;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (squeeze_armed && m_axis_tvalid_o) begin
        squeeze_armed = 1'b0;
        stall = SQUEEZE_HOLD;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, MAX_IDLE);
      end else begin
        stall = 0;
      end
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_digest
    digest_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (digest_q.size() == 0) begin
        report_mismatch("digest word with none pending", m_axis_tdata_o, '0);
      end else begin
        want = digest_q.pop_front();
        if (m_axis_tdata_o !== want.word)
          report_mismatch("digest word", m_axis_tdata_o, want.word);
        if (m_axis_tuser_o !== want.index)
          report_mismatch("word index", 32'(m_axis_tuser_o), 32'(want.index));
        if (m_axis_tlast_o !== want.last)
          report_mismatch("last word flag", 32'(m_axis_tlast_o), 32'(want.last));
      end
    end
  end

  // Ends the run if no transaction happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: files.f
rtl/core/sha1_pkg.sv
rtl/core/sha1_compress.sv
rtl/core/sha1_hash_engine.sv
sim/tb_sha1_hash_engine.sv
